// ----- sv/planar_arm_move_selector_top_macros.svh -----
// assertion macros for the planar arm move selector
// used by the rtl files that carry concurrent checks
`ifndef PLANAR_ARM_MOVE_SELECTOR_TOP_MACROS_SVH
`define PLANAR_ARM_MOVE_SELECTOR_TOP_MACROS_SVH
`ifndef SYNTH
`define PAMS_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("label");
`define PAMS_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("label");
`else
`define PAMS_ASSERT_IMP(label, clk, rst_n, a, c)
`define PAMS_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ----- sv/pams_pkg.sv -----
// package for the planar arm move selector
// types, constants and the arctangent table, no dependencies
`default_nettype none
package pams_pkg;
  localparam int MAX_CANDIDATES_DEF = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam logic signed [63:0] DEG_TO_RAD_Q32 = 64'sd74961321;
  localparam logic signed [31:0] PI_Q24 = 32'sd52707179;
  localparam logic signed [31:0] TWO_PI_Q24 = 32'sd105414357;
  localparam logic signed [31:0] HALF_PI_Q24 = 32'sd26353589;
  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032875;
  // floor(2^57 / two pi in q24), quotient estimate for the angle wrap
  localparam logic signed [33:0] RECIP_TWO_PI_Q57 = 34'sd1367130552;
  localparam logic [47:0] COST_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [1:0] REG_LINK_ONE = 2'd0;
  localparam logic [1:0] REG_LINK_TWO = 2'd1;
  localparam logic [1:0] REG_LINK_THREE = 2'd2;
  localparam logic [1:0] REG_STEP_WEIGHT = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ANGLE, ST_REDUCE, ST_FOLD, ST_ROT, ST_ACC, ST_RAD, ST_RSQ,
    ST_DIFF, ST_PCOST, ST_ACOST, ST_DONE, ST_OUT
  } state_t;

  typedef struct packed {
    logic [13:0] len0;
    logic [13:0] len1;
    logic [13:0] len2;
    logic [7:0] weight;
  } cfg_t;

  function automatic logic signed [31:0] atan_q24(input logic [4:0] i);
    case (i)
      5'd0: atan_q24 = 32'sd13176795;
      5'd1: atan_q24 = 32'sd7778716;
      5'd2: atan_q24 = 32'sd4110060;
      5'd3: atan_q24 = 32'sd2086331;
      5'd4: atan_q24 = 32'sd1047214;
      5'd5: atan_q24 = 32'sd524117;
      5'd6: atan_q24 = 32'sd262123;
      5'd7: atan_q24 = 32'sd131069;
      default: atan_q24 = (i < 5'd24) ? (32'sd1 <<< (5'd24 - i)) : 32'sd0;
    endcase
  endfunction
endpackage
`default_nettype wire

// ----- sv/pams_cfg_regs.sv -----
// apb-style register file for link lengths and step weight
// depends on pams_pkg
`default_nettype none
module pams_cfg_regs import pams_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output cfg_t             cfg
);
  cfg_t cfg_r;
  logic [1:0] idx;
  assign idx = cfg_paddr[3:2];
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.len0 <= 14'd7731;
      cfg_r.len1 <= 14'd6886;
      cfg_r.len2 <= 14'd2714;
      cfg_r.weight <= 8'd102;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      case (idx)
        REG_LINK_ONE: cfg_r.len0 <= cfg_pwdata[13:0];
        REG_LINK_TWO: cfg_r.len1 <= cfg_pwdata[13:0];
        REG_LINK_THREE: cfg_r.len2 <= cfg_pwdata[13:0];
        REG_STEP_WEIGHT: cfg_r.weight <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = 32'd0;
    if (cfg_paddr[1:0] == 2'b00) begin
      case (idx)
        REG_LINK_ONE: cfg_prdata = {18'd0, cfg_r.len0};
        REG_LINK_TWO: cfg_prdata = {18'd0, cfg_r.len1};
        REG_LINK_THREE: cfg_prdata = {18'd0, cfg_r.len2};
        REG_STEP_WEIGHT: cfg_prdata = {24'd0, cfg_r.weight};
        default: cfg_prdata = 32'd0;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- sv/pams_cordic.sv -----
// shared cordic rotation unit, one micro-rotation per cycle
// depends on pams_pkg
`default_nettype none
module pams_cordic import pams_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] angle,
  output logic                    busy,
  output logic signed [32:0]      cos_q30,
  output logic signed [32:0]      sin_q30
);
  localparam int NSTEP = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  logic signed [32:0] x_r, y_r;
  logic signed [31:0] z_r;
  logic [4:0] i_r;
  logic busy_r;
  logic signed [32:0] xs, ys;
  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign busy = busy_r;
  assign cos_q30 = x_r;
  assign sin_q30 = y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r <= 5'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      i_r <= 5'd0;
      x_r <= 33'(CORDIC_GAIN_Q30);
      y_r <= 33'sd0;
      z_r <= angle;
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_q24(i_r);
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_q24(i_r);
      end
      i_r <= i_r + 5'd1;
      if (i_r == 5'(NSTEP - 1)) busy_r <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ----- sv/pams_core.sv -----
// sequencer and shared multiplier for costing and keeping candidates
// depends on pams_pkg and pams_cordic
`default_nettype none
`include "planar_arm_move_selector_top_macros.svh"
module pams_core import pams_pkg::*; #(
  parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  cfg_t              cfg,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [175:0] in_item,
  input  wire logic         in_last,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [103:0]      out_item
);
  localparam int CW = $clog2(MAX_CANDIDATES + 1);

  state_t st_r, st_nxt;
  logic signed [15:0] tx_r, ty_r;
  logic signed [15:0] th_r [3];
  logic signed [15:0] pl_r [3];
  logic signed [15:0] mi_r [3];
  logic last_r;
  logic [1:0] j_r;
  logic signed [17:0] thsum_r;
  logic signed [18:0] dsum_r;
  logic signed [33:0] ang_r;
  logic signed [6:0] q_r;
  logic flip_r;
  logic signed [63:0] sx_r, sy_r;
  logic signed [47:0] rsq_r;
  logic signed [31:0] r_r;
  logic signed [33:0] dx_r, dy_r;
  logic [47:0] pcost_r;
  logic [63:0] cost_r;
  logic [47:0] lowest_r;
  logic [15:0] kept_r [6];
  logic [3:0] kidx_r;
  logic found_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] pos_r;
  logic admit_r;
  logic [103:0] out_r;
  logic ov_r;

  logic cstart, cbusy;
  logic signed [32:0] cc, cs;
  logic signed [31:0] cang;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  logic signed [33:0] red;
  logic [1:0] ph_r;
  logic [47:0] cost_sat;
  logic take;

  pams_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cstart), .angle(cang),
    .busy(cbusy), .cos_q30(cc), .sin_q30(cs)
  );

  assign mul_p = mul_a * mul_b;
  assign in_ready = (st_r == ST_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_item = out_r;
  assign cang = ang_r[31:0];
  assign red = ang_r + 34'(PI_Q24);
  assign cost_sat = (cost_r > 64'(COST_MAX)) ? COST_MAX : cost_r[47:0];
  assign take = admit_r && (!found_r || cost_sat < lowest_r);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_valid && in_ready) st_nxt = ST_ANGLE;
      ST_ANGLE: st_nxt = admit_r ? ST_REDUCE : ST_DONE;
      ST_REDUCE: if (ph_r == 2'd2) st_nxt = ST_FOLD;
      ST_FOLD: st_nxt = ST_ROT;
      ST_ROT: if (!cstart && !cbusy && ph_r == 2'd2) st_nxt = ST_ACC;
      ST_ACC: if (ph_r == 2'd1) st_nxt = ST_RAD;
      ST_RAD: st_nxt = ST_RSQ;
      ST_RSQ: st_nxt = (j_r == 2'd2) ? ST_DIFF : ST_ANGLE;
      ST_DIFF: st_nxt = ST_PCOST;
      ST_PCOST: if (ph_r == 2'd1) st_nxt = ST_ACOST;
      ST_ACOST: if (ph_r == 2'd1) st_nxt = ST_DONE;
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a = 34'sd0;
    mul_b = 34'sd0;
    cstart = 1'b0;
    case (st_r)
      ST_ANGLE: begin
        mul_a = 34'(dsum_r);
        mul_b = 34'(DEG_TO_RAD_Q32);
      end
      ST_REDUCE: begin
        if (ph_r == 2'd0) begin
          mul_a = red;
          mul_b = RECIP_TWO_PI_Q57;
        end else begin
          mul_a = 34'(q_r);
          mul_b = 34'(TWO_PI_Q24);
        end
      end
      ST_ROT: cstart = (ph_r == 2'd0);
      ST_ACC: begin
        mul_a = (j_r == 2'd0) ? 34'(cfg.len0) : (j_r == 2'd1) ? 34'(cfg.len1) : 34'(cfg.len2);
        mul_b = (ph_r == 2'd0) ? 34'(cc) : 34'(cs);
        if (flip_r) mul_b = -mul_b;
      end
      ST_RAD: begin
        mul_a = 34'(pl_r[j_r]) + 34'(mi_r[j_r]);
        mul_b = 34'(DEG_TO_RAD_Q32);
      end
      ST_RSQ: begin
        mul_a = 34'(r_r);
        mul_b = 34'(r_r);
      end
      ST_PCOST: begin
        mul_a = (ph_r == 2'd0) ? dx_r : dy_r;
        mul_b = mul_a;
      end
      ST_ACOST: begin
        mul_a = (ph_r == 2'd0) ? 34'(rsq_r[47:16]) : 34'(rsq_r[15:0]);
        mul_b = 34'(cfg.weight);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
      found_r <= 1'b0;
      lowest_r <= COST_MAX;
      kidx_r <= 4'd0;
      cnt_r <= '0;
      ph_r <= 2'd0;
      for (int k = 0; k < 6; k++) kept_r[k] <= 16'd0;
    end else begin
      st_r <= st_nxt;
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (st_r)
        ST_IDLE: if (in_valid && in_ready) begin
          tx_r <= in_item[15:0];
          ty_r <= in_item[31:16];
          for (int k = 0; k < 3; k++) begin
            th_r[k] <= in_item[32+16*k +: 16];
            pl_r[k] <= in_item[80+16*k +: 16];
            mi_r[k] <= in_item[128+16*k +: 16];
          end
          last_r <= in_last;
          pos_r <= cnt_r;
          if (cnt_r < CW'(MAX_CANDIDATES)) cnt_r <= cnt_r + 1'b1;
          admit_r <= (cnt_r < CW'(MAX_CANDIDATES)) &&
            !((in_item[95:80] != 16'd0 && in_item[95:80] == in_item[143:128]) ||
              (in_item[111:96] != 16'd0 && in_item[111:96] == in_item[159:144]) ||
              (in_item[127:112] != 16'd0 && in_item[127:112] == in_item[175:160]));
          j_r <= 2'd0;
          dsum_r <= 19'(signed'(in_item[95:80])) - 19'(signed'(in_item[143:128]));
          thsum_r <= 18'(signed'(in_item[47:32]));
          sx_r <= 64'sd0;
          sy_r <= 64'sd0;
          rsq_r <= 48'sd0;
          ph_r <= 2'd0;
        end
        ST_ANGLE: ang_r <= 34'(thsum_r) * 34'sd4096 + 34'(mul_p >>> 12);
        ST_REDUCE: begin
          if (ph_r == 2'd0) begin
            q_r <= 7'(mul_p >>> 57);
            ph_r <= 2'd1;
          end else if (ph_r == 2'd1) begin
            ang_r <= red - 34'(mul_p);
            ph_r <= 2'd2;
          end else begin
            if (ang_r >= 34'(TWO_PI_Q24))
              ang_r <= ang_r - 34'(TWO_PI_Q24) - 34'(PI_Q24);
            else if (ang_r < 34'sd0)
              ang_r <= ang_r + 34'(TWO_PI_Q24) - 34'(PI_Q24);
            else
              ang_r <= ang_r - 34'(PI_Q24);
            ph_r <= 2'd0;
          end
        end
        ST_FOLD: begin
          flip_r <= 1'b0;
          if (ang_r > 34'(HALF_PI_Q24)) begin
            ang_r <= ang_r - 34'(PI_Q24);
            flip_r <= 1'b1;
          end else if (ang_r < -34'(HALF_PI_Q24)) begin
            ang_r <= ang_r + 34'(PI_Q24);
            flip_r <= 1'b1;
          end
        end
        ST_ROT: begin
          if (ph_r == 2'd0) ph_r <= 2'd1;
          else if (ph_r == 2'd1 && !cbusy) ph_r <= 2'd2;
          else if (ph_r == 2'd2) ph_r <= 2'd0;
        end
        ST_ACC: begin
          if (ph_r == 2'd0) begin
            sx_r <= sx_r + 64'(mul_p);
            ph_r <= 2'd1;
          end else begin
            sy_r <= sy_r + 64'(mul_p);
            ph_r <= 2'd0;
          end
        end
        ST_RAD: r_r <= 32'(mul_p >>> 24);
        ST_RSQ: begin
          rsq_r <= rsq_r + 48'(mul_p);
          if (j_r != 2'd2) begin
            j_r <= j_r + 2'd1;
            thsum_r <= thsum_r + 18'(th_r[j_r + 2'd1]);
            dsum_r <= dsum_r + 19'(pl_r[j_r + 2'd1]) - 19'(mi_r[j_r + 2'd1]);
          end
        end
        ST_DIFF: begin
          dx_r <= 34'(sx_r >>> 30) - 34'(tx_r);
          dy_r <= 34'(sy_r >>> 30) - 34'(ty_r);
        end
        ST_PCOST: begin
          if (ph_r == 2'd0) begin
            pcost_r <= 48'(mul_p);
            ph_r <= 2'd1;
          end else begin
            cost_r <= 64'(pcost_r) + 64'(mul_p);
            ph_r <= 2'd0;
          end
        end
        ST_ACOST: begin
          if (ph_r == 2'd0) begin
            cost_r <= cost_r + 64'(mul_p);
            ph_r <= 2'd1;
          end else begin
            cost_r <= cost_r + 64'(mul_p >>> 16);
            ph_r <= 2'd0;
          end
        end
        ST_DONE: begin
          if (last_r) begin
            ov_r <= 1'b1;
            if (take)
              out_r <= {3'd0,
                        mi_r[2], mi_r[1], mi_r[0], pl_r[2], pl_r[1], pl_r[0],
                        4'(pos_r), 1'b1};
            else if (found_r)
              out_r <= {3'd0, kept_r[5], kept_r[4], kept_r[3], kept_r[2], kept_r[1],
                        kept_r[0], kidx_r, 1'b1};
            else
              out_r <= 104'd0;
            found_r <= 1'b0;
            lowest_r <= COST_MAX;
            kidx_r <= 4'd0;
            cnt_r <= '0;
            for (int k = 0; k < 6; k++) kept_r[k] <= 16'd0;
          end else if (take) begin
            lowest_r <= cost_sat;
            found_r <= 1'b1;
            kidx_r <= 4'(pos_r);
            for (int k = 0; k < 3; k++) begin
              kept_r[k] <= pl_r[k];
              kept_r[3+k] <= mi_r[k];
            end
          end
        end
        default: ;
      endcase
    end
  end

  `PAMS_ASSERT_IMP(a_no_accept_busy, clk, rst_n, st_r != ST_IDLE, !in_ready)
  `PAMS_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(MAX_CANDIDATES))
  `PAMS_ASSERT_NXT(a_out_on_last, clk, rst_n, st_r == ST_DONE && last_r, out_valid)
endmodule
`default_nettype wire

// ----- sv/planar_arm_move_selector_top.sv -----
// sequence: an admissible candidate passes angle, reduce, fold, rotate, accumulate, radius and
// radius square for each of the three joints, then diff, the two cost steps and done, all on
// the shared cordic and multiplier; a skipped candidate goes from angle straight to done
// one request at a time: not ready while a request is in work or a result waits
// reset: synchronous active low, clears the kept candidate and the registers to defaults
// top level of the planar arm move selector, depends on pams_pkg, pams_cfg_regs, pams_core
`default_nettype none
module planar_arm_move_selector_top import pams_pkg::*; #(
  parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // target_x, target_y, joint_angle_0..2, plus_step_0..2, minus_step_0..2
  input  wire logic [175:0] in_tdata,
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // found, chosen_index, chosen_plus_0..2, chosen_minus_0..2, zero pad
  output logic [103:0]      out_tdata,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [3:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  cfg_t cfg;
  assign cfg_pready = 1'b1;

  pams_cfg_regs u_regs (
    .clk(clk), .rst_n(rst_n), .cfg_psel(cfg_psel), .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .cfg(cfg)
  );

  pams_core #(.MAX_CANDIDATES(MAX_CANDIDATES), .CORDIC_STEPS(CORDIC_STEPS)) u_core (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_item(in_tdata), .in_last(in_tlast), .out_valid(out_tvalid),
    .out_ready(out_tready), .out_item(out_tdata)
  );
endmodule
`default_nettype wire
